/* hdl/slcf_pkg.sv */
// ============================================================================
// slcf_pkg: shared types and constants of the sync/length/command frame parser
// Holds the frame descriptor that travels from the byte front end through the
// frame queue to the result back end, plus header, command and register codes.
// ============================================================================
package slcf_pkg;

  // Header layout: two sync bytes, payload length, command.
  localparam int HDR_LEN   = 4;
  localparam int HDR_IDX_W = $clog2(HDR_LEN);

  // Byte counter of the current frame: four header bytes plus up to 255
  // payload bytes, so it never exceeds 259.
  localparam int CNT_W = 9;

  // Payload bytes that corner decoding can reach: four corners of four bytes.
  localparam int STORE_BYTES = 16;
  localparam int STORE_IDX_W = $clog2(STORE_BYTES);

  // Default number of completed frames the queue can hold.
  localparam int QUEUE_DEPTH_DEF = 2;

  // Command byte codes.
  localparam logic [7:0] CMD_POINT = 8'd1;
  localparam logic [7:0] CMD_RECT  = 8'd2;

  // Result frame kinds.
  localparam logic KIND_POINT = 1'b0;
  localparam logic KIND_RECT  = 1'b1;

  // Last corner of a rectangle frame.
  localparam logic [1:0] CORNER_LAST = 2'd3;

  // Configuration register index, taken from paddr[2].
  localparam logic REG_SYNC_FIRST  = 1'b0;
  localparam logic REG_SYNC_SECOND = 1'b1;

  typedef logic [STORE_BYTES-1:0][7:0] slcf_payload_t;

  // One completed frame that produces results.
  typedef struct packed {
    logic          kind;
    logic [15:0]   count;
    slcf_payload_t payload;
  } slcf_desc_t;

  // Queue occupancy seen by the front and back ends.
  typedef struct packed {
    logic full;
    logic empty;
  } slcf_qstat_t;

endpackage

/* hdl/slcf_front.sv */
// ============================================================================
// slcf_front: byte front end
// Tracks the header window, hunts for the sync pair, collects payload bytes
// and hands a descriptor to the queue for each completed point or rectangle.
// ============================================================================
module slcf_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  logic [7:0]          rx_byte,
  input  logic [7:0]          sync_first,
  input  logic [7:0]          sync_second,
  output logic                push,
  output slcf_pkg::slcf_desc_t push_desc
);
  import slcf_pkg::*;

  localparam logic [CNT_W-1:0] HDR_CNT   = CNT_W'(HDR_LEN);
  localparam logic [CNT_W-1:0] HUNT_CNT  = CNT_W'(HDR_LEN - 1);
  localparam logic [CNT_W-1:0] STORE_CNT = CNT_W'(STORE_BYTES);

  logic [CNT_W-1:0]             cnt_r, cnt_nxt, cnt_inc, pl_off, frame_end;
  logic [HDR_LEN-1:0][7:0]      hw_r, hw_wr, hw_nxt;
  slcf_payload_t                pl_r, pl_nxt;
  logic [15:0]                  upd_r, upd_nxt;

  assign cnt_inc   = cnt_r + CNT_W'(1);
  assign pl_off    = cnt_r - HDR_CNT;
  assign frame_end = CNT_W'(hw_wr[2]) + HDR_CNT;

  // Place the incoming byte into the header window or the payload store.
  always_comb begin
    hw_wr  = hw_r;
    pl_nxt = pl_r;
    if (take) begin
      if (cnt_r < HDR_CNT) begin
        hw_wr[cnt_r[HDR_IDX_W-1:0]] = rx_byte;
      end else if (pl_off < STORE_CNT) begin
        pl_nxt[pl_off[STORE_IDX_W-1:0]] = rx_byte;
      end
    end
  end

  // Header check and frame completion.
  always_comb begin
    hw_nxt  = hw_wr;
    cnt_nxt = cnt_r;
    upd_nxt = upd_r;
    push    = 1'b0;
    if (take) begin
      priority if (cnt_inc < HDR_CNT) begin
        cnt_nxt = cnt_inc;
      end else if (hw_wr[0] != sync_first || hw_wr[1] != sync_second) begin
        // Slide the window by one byte and keep hunting.
        hw_nxt[0] = hw_wr[1];
        hw_nxt[1] = hw_wr[2];
        hw_nxt[2] = hw_wr[3];
        cnt_nxt   = HUNT_CNT;
      end else if (cnt_inc < frame_end) begin
        cnt_nxt = cnt_inc;
      end else begin
        cnt_nxt = '0;
        if (hw_wr[3] == CMD_POINT || hw_wr[3] == CMD_RECT) begin
          push    = 1'b1;
          upd_nxt = upd_r + 16'd1;
        end
      end
    end
  end

  assign push_desc.kind    = (hw_wr[3] == CMD_RECT) ? KIND_RECT : KIND_POINT;
  assign push_desc.count   = upd_r + 16'd1;
  assign push_desc.payload = pl_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      hw_r  <= '0;
      pl_r  <= '0;
      upd_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      hw_r  <= hw_nxt;
      pl_r  <= pl_nxt;
      upd_r <= upd_nxt;
    end
  end

endmodule

/* hdl/slcf_queue.sv */
// ============================================================================
// slcf_queue: frame descriptor queue
// A small first-in first-out buffer that decouples byte intake from result
// delivery, so each side stalls on its own.
// ============================================================================
module slcf_queue #(
  parameter int DEPTH = slcf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  slcf_pkg::slcf_desc_t  push_desc,
  input  logic                  pop,
  output slcf_pkg::slcf_desc_t  head_desc,
  output slcf_pkg::slcf_qstat_t stat
);
  import slcf_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(DEPTH);

  slcf_desc_t       mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic             do_push, do_pop;

  assign stat.full  = (occ_r == OCC_FULL);
  assign stat.empty = (occ_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_desc  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    occ_nxt    = occ_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      occ_nxt = occ_r + OCC_W'(1);
    end else if (do_pop && !do_push) begin
      occ_nxt = occ_r - OCC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      occ_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      occ_r    <= occ_nxt;
    end
  end

endmodule

/* hdl/slcf_back.sv */
// ============================================================================
// slcf_back: result back end
// Walks the corners of the frame at the queue head and presents one point
// per beat, releasing the descriptor after the last beat is taken.
// ============================================================================
module slcf_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  slcf_pkg::slcf_desc_t  head_desc,
  input  slcf_pkg::slcf_qstat_t stat,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_frame_kind,
  output logic [1:0]            out_corner_index,
  output logic signed [15:0]    out_point_x,
  output logic signed [15:0]    out_point_y,
  output logic [15:0]           out_update_count,
  output logic                  out_last_of_frame
);
  import slcf_pkg::*;

  logic [1:0]             corner_r, corner_nxt;
  logic [STORE_IDX_W-1:0] base;
  logic                   beat;

  assign base = {corner_r, 2'b00};

  assign out_valid         = !stat.empty;
  assign out_frame_kind    = head_desc.kind;
  assign out_corner_index  = corner_r;
  assign out_point_x       = {head_desc.payload[base], head_desc.payload[base + 4'd1]};
  assign out_point_y       = {head_desc.payload[base + 4'd2], head_desc.payload[base + 4'd3]};
  assign out_update_count  = head_desc.count;
  assign out_last_of_frame = (head_desc.kind == KIND_POINT) || (corner_r == CORNER_LAST);

  assign beat = out_valid && out_ready;
  assign pop  = beat && out_last_of_frame;

  always_comb begin
    corner_nxt = corner_r;
    if (beat) begin
      corner_nxt = out_last_of_frame ? 2'd0 : corner_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      corner_r <= '0;
    end else begin
      corner_r <= corner_nxt;
    end
  end

endmodule

/* hdl/sync_length_cmd_frame_parser.sv */
// ============================================================================
// sync_length_cmd_frame_parser: sync/length/command frame parser
// Parses a received byte stream into point and rectangle results.
// ============================================================================
// The block takes one received byte per beat on the in_ channel and hunts for
// a four-byte header made of the two sync bytes (registers at byte addresses 0
// and 4, reset 0x12 and 0x34), a payload length and a command. A frame with
// command 1 yields one beat carrying a big-endian signed point from payload
// bytes 0 to 3; command 2 yields four beats, corners A to D from payload
// bytes 0 to 15; other commands are swallowed. Payload bytes a short frame
// does not send keep the values of earlier frames (zero after reset), and
// bytes past the sixteenth are counted but dropped. A byte is accepted every
// cycle unless the frame queue, QUEUE_DEPTH frames deep, is full; results
// leave the back end at one beat per cycle while out_ready is high, once the
// completing byte is in the queue and earlier results are out. The queue
// bounds intake: it fills only when results are drained more slowly than
// frames complete, as with four-byte rectangles against a stalled result side.
// ============================================================================
module sync_length_cmd_frame_parser #(
  parameter int QUEUE_DEPTH = slcf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // Configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // Received byte channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  // Result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_frame_kind,
  output logic [1:0]         out_corner_index,
  output logic signed [15:0] out_point_x,
  output logic signed [15:0] out_point_y,
  output logic [15:0]        out_update_count,
  output logic               out_last_of_frame
);
  import slcf_pkg::*;

  logic [7:0]  sync_first_r, sync_second_r;
  logic        cfg_wr;
  logic        take;
  logic        push, pop;
  slcf_desc_t  push_desc, head_desc;
  slcf_qstat_t qstat;

  // Configuration registers. The register index is paddr[2]; the low address
  // bits are not decoded.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= 8'h12;
      sync_second_r <= 8'h34;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_SYNC_FIRST:  sync_first_r  <= pwdata[7:0];
        REG_SYNC_SECOND: sync_second_r <= pwdata[7:0];
        default:         sync_first_r  <= sync_first_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SYNC_FIRST:  prdata = {24'd0, sync_first_r};
      REG_SYNC_SECOND: prdata = {24'd0, sync_second_r};
      default:         prdata = '0;
    endcase
  end

  // Intake stalls only when no room is left for a completed frame.
  assign in_ready = !qstat.full;
  assign take     = in_valid && in_ready;

  slcf_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .rx_byte     (in_rx_byte),
    .sync_first  (sync_first_r),
    .sync_second (sync_second_r),
    .push        (push),
    .push_desc   (push_desc)
  );

  slcf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head_desc (head_desc),
    .stat      (qstat)
  );

  slcf_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_desc         (head_desc),
    .stat              (qstat),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_frame_kind    (out_frame_kind),
    .out_corner_index  (out_corner_index),
    .out_point_x       (out_point_x),
    .out_point_y       (out_point_y),
    .out_update_count  (out_update_count),
    .out_last_of_frame (out_last_of_frame)
  );

  // A completed frame must always find room in the queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !qstat.full)
    else $error("frame completed while the queue was full");

  // A single point is one beat at corner zero.
  a_point_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_kind == KIND_POINT) |-> (out_corner_index == 2'd0 && out_last_of_frame))
    else $error("single point frame not delivered as one beat");

  // After a non-final corner is taken, the same frame continues with the next corner.
  a_corner_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_of_frame) |=>
      (out_valid && $stable(out_update_count) && out_corner_index == $past(out_corner_index) + 2'd1))
    else $error("rectangle corners not delivered in order");

endmodule

/* verif/sync_length_cmd_frame_parser_tb.sv */
// ============================================================================
// sync_length_cmd_frame_parser_tb: self-checking bench for the frame parser
// Streams serial bytes into the parser and predicts every point beat it must
// return. Each returned beat is compared field by field against the oldest
// prediction. The run covers several sync byte settings, random idle gaps on
// both channels, a long result-side stall and a pause for the results to drain.
// ============================================================================
module sync_length_cmd_frame_parser_tb;
  import slcf_pkg::*;

  localparam int RESET_CYCLES  = 9;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int LONG_STALL    = 300;

  // A command byte that the parser swallows without a result.
  localparam logic [7:0] CMD_UNKNOWN = 8'hFF;

  // Byte addresses of the two sync registers.
  localparam logic [2:0] ADDR_SYNC_FIRST  = {REG_SYNC_FIRST, 2'b00};
  localparam logic [2:0] ADDR_SYNC_SECOND = {REG_SYNC_SECOND, 2'b00};

  // One serial byte waiting to be sent. The sender first idles for the wait in
  // gap, then offers the byte. With drain set, it also holds the byte back until
  // every predicted point has come out.
  typedef struct {
    logic [7:0] data;
    int         gap;
    bit         drain;
  } serial_byte_t;

  // One predicted result beat.
  typedef struct {
    logic               kind;
    logic [1:0]         corner;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [15:0]        count;
    logic               last;
  } point_beat_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  logic       in_valid   = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = '0;

  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_frame_kind;
  logic [1:0]         out_corner_index;
  logic signed [15:0] out_point_x;
  logic signed [15:0] out_point_y;
  logic [15:0]        out_update_count;
  logic               out_last_of_frame;

  sync_length_cmd_frame_parser u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_frame_kind    (out_frame_kind),
    .out_corner_index  (out_corner_index),
    .out_point_x       (out_point_x),
    .out_point_y       (out_point_y),
    .out_update_count  (out_update_count),
    .out_last_of_frame (out_last_of_frame)
  );

  // Two time units per period: low for one, high for one.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Parser prediction. This is the bench's own copy of the sync registers,
  // the sliding header window, the frame byte counter, the payload store and
  // the decoded frame counter.
  // --------------------------------------------------------------------------
  logic [7:0]       sync_a = 8'h12;
  logic [7:0]       sync_b = 8'h34;
  logic [7:0]       hdr_win [HDR_LEN] = '{default: 8'h00};
  logic [CNT_W-1:0] frame_bytes = '0;
  logic [7:0]       payload_mem [STORE_BYTES] = '{default: 8'h00};
  logic [15:0]      frames_decoded = '0;

  point_beat_t  pending_points [$];
  serial_byte_t serial_q [$];
  int           mismatches = 0;

  // Decodes one corner from the payload store as it stands now. Each corner
  // takes four big-endian bytes: x first, then y.
  function automatic void push_point(logic kind, logic [1:0] corner);
    point_beat_t p;
    int          base;
    base     = 4 * int'(corner);
    p.kind   = kind;
    p.corner = corner;
    p.x      = {payload_mem[base], payload_mem[base + 1]};
    p.y      = {payload_mem[base + 2], payload_mem[base + 3]};
    p.count  = frames_decoded;
    p.last   = (kind == KIND_POINT) || (corner == CORNER_LAST);
    pending_points.push_back(p);
  endfunction

  // Takes one accepted byte and queues whatever point beats it completes.
  function automatic void parse_byte(logic [7:0] b);
    int pos;
    // Header bytes go to the window. Payload bytes go to the store, and those
    // past its end only count toward the length.
    if (frame_bytes < HDR_LEN) begin
      hdr_win[frame_bytes[1:0]] = b;
    end else begin
      pos = int'(frame_bytes) - HDR_LEN;
      if (pos < STORE_BYTES) begin
        payload_mem[pos] = b;
      end
    end
    frame_bytes = frame_bytes + 1'b1;
    if (frame_bytes < HDR_LEN) begin
      return;
    end
    // A full window that does not start with the sync pair slides by one byte.
    if (hdr_win[0] != sync_a || hdr_win[1] != sync_b) begin
      hdr_win[0]  = hdr_win[1];
      hdr_win[1]  = hdr_win[2];
      hdr_win[2]  = hdr_win[3];
      frame_bytes = CNT_W'(HDR_LEN - 1);
      return;
    end
    if (int'(frame_bytes) < int'(hdr_win[2]) + HDR_LEN) begin
      return;
    end
    // The frame is complete. Unknown commands leave the counter alone.
    frame_bytes = '0;
    if (hdr_win[3] == CMD_POINT) begin
      frames_decoded = frames_decoded + 16'd1;
      push_point(KIND_POINT, 2'd0);
    end else if (hdr_win[3] == CMD_RECT) begin
      frames_decoded = frames_decoded + 16'd1;
      for (int c = 0; c < 4; c++) begin
        push_point(KIND_RECT, 2'(c));
      end
    end
  endfunction

  function automatic void check_field(string name, logic signed [31:0] want,
                                      logic signed [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Idle gaps. Each side draws a wait for every beat. A calm percentage of
  // 100 gives stretches with no idling at all.
  // --------------------------------------------------------------------------
  function automatic int draw_gap(int calm_pct);
    if (int'($urandom_range(0, 99)) < calm_pct) begin
      return 0;
    end
    return int'($urandom_range(0, 11));
  endfunction

  function automatic int pick_calm();
    case ($urandom_range(0, 2))
      0:       return 100;
      1:       return 0;
      default: return 60;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus builders. They only fill serial_q, and the driver sends it.
  // --------------------------------------------------------------------------
  function automatic void queue_byte(logic [7:0] data, int calm_pct, bit drain);
    serial_byte_t s;
    s.data  = data;
    s.gap   = draw_gap(calm_pct);
    s.drain = drain;
    serial_q.push_back(s);
  endfunction

  function automatic void queue_header(int len, logic [7:0] cmd, int calm_pct, bit drain);
    queue_byte(sync_a, calm_pct, drain);
    queue_byte(sync_b, calm_pct, 1'b0);
    queue_byte(8'(len), calm_pct, 1'b0);
    queue_byte(cmd, calm_pct, 1'b0);
  endfunction

  function automatic void queue_frame(int len, logic [7:0] cmd, int calm_pct, bit drain);
    queue_header(len, cmd, calm_pct, drain);
    for (int i = 0; i < len; i++) begin
      queue_byte(8'($urandom), calm_pct, 1'b0);
    end
  endfunction

  // Random traffic, mostly well-formed frames with random payloads. Some
  // payloads run past the store. The rest is loose noise, sync pairs with a
  // wrong second byte and frames cut short, so that the next bytes fill the
  // payload of the cut frame.
  function automatic void queue_random(int target);
    int         added;
    int         pick;
    int         len;
    int         calm;
    logic [7:0] cmd;
    added = 0;
    while (added < target) begin
      calm = pick_calm();
      pick = int'($urandom_range(0, 99));
      if (pick < 70) begin
        len = ($urandom_range(0, 4) == 0) ? int'($urandom_range(17, 40))
                                          : int'($urandom_range(0, 16));
        case ($urandom_range(0, 4))
          0, 1:    cmd = CMD_POINT;
          2, 3:    cmd = CMD_RECT;
          default: cmd = 8'($urandom);
        endcase
        queue_frame(len, cmd, calm, $urandom_range(0, 9) == 0);
        added += HDR_LEN + len;
      end else if (pick < 85) begin
        len = int'($urandom_range(1, 5));
        for (int i = 0; i < len; i++) begin
          queue_byte(8'($urandom), calm, 1'b0);
        end
        added += len;
      end else if (pick < 93) begin
        queue_byte(sync_a, calm, 1'b0);
        queue_byte(~sync_b, calm, 1'b0);
        added += 2;
      end else begin
        len = int'($urandom_range(2, 8));
        queue_header(len, CMD_RECT, calm, 1'b0);
        for (int i = 0; i < len / 2; i++) begin
          queue_byte(8'($urandom), calm, 1'b0);
        end
        added += HDR_LEN + len / 2;
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Configuration writes: a setup phase, then an access phase that completes
  // at the first rising edge with pready high. The upper data bits carry
  // noise, which the 8-bit registers must drop.
  // --------------------------------------------------------------------------
  task automatic write_reg(input logic [2:0] addr, input logic [7:0] value);
    logic [31:0] word;
    word      = $urandom();
    word[7:0] = value;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_SYNC_FIRST) begin
      sync_a = value;
    end else if (addr == ADDR_SYNC_SECOND) begin
      sync_b = value;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Waits until every byte has been sent and every point has come back. It
  // then gives a frame still in progress time to settle, since a swallowed
  // command leaves nothing to wait for.
  task automatic wait_idle();
    while (serial_q.size() != 0 || in_valid || pending_points.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Handshake sampling and checking at the rising edge. The taken flags tell
  // the falling-edge processes which beats moved at the edge just past.
  // --------------------------------------------------------------------------
  logic in_taken  = 1'b0;
  logic out_taken = 1'b0;

  always @(posedge clk) begin : monitor
    point_beat_t want;
    in_taken  <= rst_n && in_valid && in_ready;
    out_taken <= rst_n && out_valid && out_ready;
    // The result side is checked before this edge's input byte is predicted.
    // A beat can never come from the byte accepted at the same edge.
    if (rst_n && out_valid && out_ready) begin
      if (pending_points.size() == 0) begin
        $error("result beat with no prediction pending");
        mismatches++;
      end else begin
        want = pending_points.pop_front();
        check_field("frame_kind", want.kind, out_frame_kind);
        check_field("corner_index", want.corner, out_corner_index);
        check_field("point_x", want.x, out_point_x);
        check_field("point_y", want.y, out_point_y);
        check_field("update_count", want.count, out_update_count);
        check_field("last_of_frame", want.last, out_last_of_frame);
      end
    end
    if (rst_n && in_valid && in_ready) begin
      parse_byte(in_rx_byte);
    end
  end

  // --------------------------------------------------------------------------
  // Byte driver. Once a byte is offered it is held unchanged until it is
  // taken. A zero gap keeps valid high into the next byte, so valid gets
  // only one assignment per edge.
  // --------------------------------------------------------------------------
  int tx_wait = 0;

  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_taken)) begin
      if (serial_q.size() == 0 || (serial_q[0].drain && pending_points.size() != 0)) begin
        in_valid <= 1'b0;
      end else if (tx_wait < serial_q[0].gap) begin
        tx_wait++;
        in_valid <= 1'b0;
      end else begin
        in_rx_byte <= serial_q[0].data;
        in_valid   <= 1'b1;
        serial_q.delete(0);
        tx_wait = 0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver. It draws a wait after every beat it takes and re-rolls
  // how calm it is every sixteen beats. A stall request from the sequence
  // below makes it hold out_ready low for a long stall set by LONG_STALL, which
  // it counts itself.
  // --------------------------------------------------------------------------
  int rx_wait    = 0;
  int rx_hold    = 0;
  int rx_calm    = 60;
  int rx_beats   = 0;
  int stall_seq  = 0;
  int stall_seen = 0;

  always @(negedge clk) begin
    if (rst_n) begin
      if (stall_seq != stall_seen) begin
        stall_seen = stall_seq;
        rx_hold    = LONG_STALL;
      end
      if (out_taken) begin
        rx_beats++;
        if (rx_beats % 16 == 0) begin
          rx_calm = pick_calm();
        end
        rx_wait = draw_gap(rx_calm);
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // A run that stops making progress ends here.
  int cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sync_length_cmd_frame_parser: mismatch");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence. Reset, then four phases with different sync bytes. The
  // registers change only once the parser has drained.
  // --------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Phase one runs at the reset sync values, written explicitly. The
    // directed frames come first. A point frame with the most negative x and
    // the most positive y fills store bytes 0 to 3. A zero-length rectangle
    // then reads corner A from those old bytes, and the other corners still
    // read zero. An unknown command follows, then noise, then a point frame
    // with only one payload byte, which overwrites only the first store byte.
    write_reg(ADDR_SYNC_FIRST, 8'h12);
    write_reg(ADDR_SYNC_SECOND, 8'h34);
    queue_header(4, CMD_POINT, 100, 1'b0);
    queue_byte(8'h80, 100, 1'b0);
    queue_byte(8'h00, 100, 1'b0);
    queue_byte(8'h7F, 100, 1'b0);
    queue_byte(8'hFF, 100, 1'b0);
    queue_header(0, CMD_RECT, 60, 1'b0);
    queue_header(0, CMD_UNKNOWN, 0, 1'b0);
    queue_byte(8'h00, 0, 1'b0);
    queue_byte(8'hFF, 0, 1'b0);
    queue_header(1, CMD_POINT, 60, 1'b0);
    queue_byte(8'h01, 60, 1'b0);
    queue_random(16);
    wait_idle();

    // Phase two uses extreme sync bytes. It opens with a rectangle whose
    // payload runs past the end of the store.
    write_reg(ADDR_SYNC_FIRST, 8'hFF);
    write_reg(ADDR_SYNC_SECOND, 8'h00);
    queue_frame(20, CMD_RECT, 100, 1'b0);
    queue_random(16);
    wait_idle();

    // Phase three uses the opposite extremes. The receiver stalls for a long
    // time while back-to-back zero-length rectangles pile up, until the frame
    // queue fills and in_ready drops. The sender then pauses until every
    // result is out before it goes on.
    write_reg(ADDR_SYNC_FIRST, 8'h00);
    write_reg(ADDR_SYNC_SECOND, 8'hFF);
    stall_seq++;
    for (int i = 0; i < 12; i++) begin
      queue_frame(0, CMD_RECT, 100, 1'b0);
    end
    queue_frame(2, CMD_POINT, 60, 1'b1);
    queue_random(16);
    wait_idle();

    // Phase four uses random sync bytes.
    write_reg(ADDR_SYNC_FIRST, 8'($urandom));
    write_reg(ADDR_SYNC_SECOND, 8'($urandom));
    queue_random(16);
    wait_idle();

    if (mismatches == 0) begin
      $display("sync_length_cmd_frame_parser: match");
    end else begin
      $display("sync_length_cmd_frame_parser: mismatch");
    end
    $finish;
  end

endmodule
